### sv/switching_median_denoise_3x3_rgb_core_assert.svh
// assertion macros for the switching median denoise core
`ifndef SWITCHING_MEDIAN_DENOISE_3X3_RGB_CORE_ASSERT_SVH
`define SWITCHING_MEDIAN_DENOISE_3X3_RGB_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMD_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("smd: forbidden condition");
`define SMD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("smd: expected next-cycle condition");
`else
`define SMD_ASSERT_NEVER(lbl, ck, rn, cond)
`define SMD_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### sv/smd_pkg.sv
// shared types and constants for the switching median denoise core
`timescale 1ns / 1ps
package smd_pkg;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT    = 4095;
	localparam int FQ_DEPTH      = 4;
	localparam int PADDR_W       = 4;

	localparam logic [8:0]  TOL_RST    = 9'd100;
	localparam logic [11:0] WIDTH_RST  = 12'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;

	typedef enum logic [1:0] {
		REG_TOLERANCE    = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef logic [23:0] pix_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_req_t;

	typedef struct packed {
		logic [10:0] pix_col;
		logic [11:0] pix_row;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic        replaced;
		logic        last_of_step;
	} out_req_t;

	typedef struct packed {
		pix_t [8:0]  win;
		logic [10:0] int_col;
		logic [11:0] int_row;
		logic [10:0] brd_col;
		logic [11:0] brd_row;
		pix_t        px;
		logic        is_int;
		logic        is_brd;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

### sv/switching_median_denoise_3x3_rgb_core.sv
// top level of the switching median denoise core
// Usage:
// - input channel: one RGB pixel per request in raster order (in_valid, in_stall,
//   in_data); one pixel is taken per clock while the result side keeps up
// - output channel: result requests (out_valid, out_stall, out_data) with the
//   pixel coordinates; border pixels come out unchanged, interior pixels one row
//   and one column later, replaced by the neighbour medians when off band
// - a pixel on the right column or bottom row of the interior rows yields two
//   results, one after the other on the output; a four-entry queue between the
//   classifying front and the median back absorbs these
// - an accepted pixel reaches its first result through the line buffer read,
//   the queue, the two median stages and the result register
// - configuration via the APB port only while the block is idle
// - reset clears counters, window and pipeline valids; line buffers hold
//   unknown data until written by the first two rows
// - when out_stall is high the result register holds and the queue fills,
//   then in_stall rises
`timescale 1ns / 1ps
module switching_median_denoise_3x3_rgb_core #(
	parameter int MAX_WIDTH = smd_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  smd_pkg::in_req_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output smd_pkg::out_req_t           out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	logic [8:0]  tolerance_q;
	logic [11:0] width_q, height_q;
	smd_pkg::reg_idx_t ridx;
	logic q_push, q_pop;
	smd_pkg::q_entry_t q_wdata, q_rdata;
	smd_pkg::q_stat_t q_stat;

	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			2'd0:    ridx = smd_pkg::REG_TOLERANCE;
			2'd1:    ridx = smd_pkg::REG_IMAGE_WIDTH;
			2'd2:    ridx = smd_pkg::REG_IMAGE_HEIGHT;
			default: ridx = smd_pkg::REG_NONE;
		endcase
	end

	always_comb begin
		case (ridx)
			smd_pkg::REG_TOLERANCE:    prdata = {23'd0, tolerance_q};
			smd_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, width_q};
			smd_pkg::REG_IMAGE_HEIGHT: prdata = {20'd0, height_q};
			default:                   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= smd_pkg::TOL_RST;
			width_q     <= smd_pkg::WIDTH_RST;
			height_q    <= smd_pkg::HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				smd_pkg::REG_TOLERANCE:    tolerance_q <= pwdata[8:0];
				smd_pkg::REG_IMAGE_WIDTH:  width_q     <= pwdata[11:0];
				smd_pkg::REG_IMAGE_HEIGHT: height_q    <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	smd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.image_width  (width_q),
		.image_height (height_q),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	smd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	smd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rdata),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.tolerance (tolerance_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);
endmodule

### sv/smd_front.sv
// front: line buffers, 3x3 window and pixel classification
`timescale 1ns / 1ps
module smd_front #(
	parameter int MAX_WIDTH = smd_pkg::MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  smd_pkg::in_req_t  in_data,
	input  logic [11:0]       image_width,
	input  logic [11:0]       image_height,
	input  smd_pkg::q_stat_t  q_stat,
	output logic              q_push,
	output smd_pkg::q_entry_t q_data
);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = $clog2(MAX_WIDTH + 1);

	logic [47:0] lb_mem [MAX_WIDTH];
	logic [47:0] rd_s1;
	logic [AW-1:0] col_q;
	logic [11:0] row_q;
	smd_pkg::pix_t [8:0] win_q;
	smd_pkg::pix_t [8:0] win_nx;
	logic s1_valid;
	logic [AW-1:0] col_s1;
	logic [10:0] icol_s1, bcol_s1;
	logic [11:0] irow_s1, row_s1;
	smd_pkg::pix_t px_s1;
	logic int_s1, brd_s1;
	logic s1_go, accept;
	logic [EW-1:0] w_eff;
	logic [11:0] h_eff;
	logic [31:0] c32, r32, w32, h32, cm1, rm1;
	logic is_int, is_brd;
	logic [AW-1:0] col_nx;
	logic [11:0] row_nx;

	always_comb begin
		if (image_width < 12'd3) begin
			w_eff = EW'(3);
		end else if (32'(image_width) > MAX_WIDTH) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(image_width);
		end
		if (image_height < 12'd3) begin
			h_eff = 12'd3;
		end else begin
			h_eff = image_height;
		end
		c32 = 32'(col_q);
		r32 = 32'(row_q);
		w32 = 32'(w_eff);
		h32 = 32'(h_eff);
		cm1 = c32 - 32'd1;
		rm1 = r32 - 32'd1;
		is_brd = (c32 == 32'd0) || (c32 >= w32 - 32'd1) || (r32 == 32'd0) || (r32 >= h32 - 32'd1);
		is_int = (c32 >= 32'd2) && (r32 >= 32'd2) && (c32 < w32) && (r32 < h32);
		if (c32 + 32'd1 >= w32) begin
			col_nx = '0;
			row_nx = (r32 + 32'd1 >= h32) ? 12'd0 : row_q + 12'd1;
		end else begin
			col_nx = col_q + AW'(1);
			row_nx = row_q;
		end
	end

	assign s1_go    = s1_valid && (!(int_s1 || brd_s1) || !q_stat.full);
	assign in_stall = s1_valid && !s1_go;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nx[k*3+0] = win_q[k*3+1];
			win_nx[k*3+1] = win_q[k*3+2];
		end
		win_nx[2] = rd_s1[47:24];
		win_nx[5] = rd_s1[23:0];
		win_nx[8] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= lb_mem[col_q];
		end
		if (s1_go) begin
			lb_mem[col_s1] <= {rd_s1[23:0], px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			px_s1   <= in_data;
			icol_s1 <= cm1[10:0];
			irow_s1 <= rm1[11:0];
			bcol_s1 <= c32[10:0];
			row_s1  <= row_q;
			int_s1  <= is_int;
			brd_s1  <= is_brd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
				col_q    <= col_nx;
				row_q    <= row_nx;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
			if (s1_go) begin
				win_q <= win_nx;
			end
		end
	end

	assign q_push = s1_go && (int_s1 || brd_s1);

	always_comb begin
		q_data         = '0;
		q_data.win     = win_nx;
		q_data.int_col = icol_s1;
		q_data.int_row = irow_s1;
		q_data.brd_col = bcol_s1;
		q_data.brd_row = row_s1;
		q_data.px      = px_s1;
		q_data.is_int  = int_s1;
		q_data.is_brd  = brd_s1;
	end
endmodule

### sv/smd_fifo.sv
// request queue between front and back
`timescale 1ns / 1ps
`include "switching_median_denoise_3x3_rgb_core_assert.svh"
module smd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  smd_pkg::q_entry_t wdata,
	input  logic              pop,
	output smd_pkg::q_entry_t rdata,
	output smd_pkg::q_stat_t  stat
);
	localparam int PW = $clog2(smd_pkg::FQ_DEPTH);
	localparam int CW = $clog2(smd_pkg::FQ_DEPTH + 1);

	smd_pkg::q_entry_t ent_q [smd_pkg::FQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (32'(count_q) == smd_pkg::FQ_DEPTH);
	assign stat.empty = (count_q == '0);
	assign rdata      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`SMD_ASSERT_NEVER(a_push_full, clk, arst_n, push && stat.full)
	`SMD_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && stat.empty)
	`SMD_ASSERT_NEVER(a_cnt_range, clk, arst_n, 32'(count_q) > smd_pkg::FQ_DEPTH)
	`SMD_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, count_q == $past(count_q) + CW'(1))
	`SMD_ASSERT_NEXT(a_cnt_dn, clk, arst_n, pop && !push, count_q == $past(count_q) - CW'(1))
endmodule

### sv/smd_back.sv
// back: neighbour medians, band check and result register
`timescale 1ns / 1ps
module smd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  smd_pkg::q_entry_t head,
	input  smd_pkg::q_stat_t  q_stat,
	output logic              pop,
	input  logic [8:0]        tolerance,
	output logic              out_valid,
	input  logic              out_stall,
	output smd_pkg::out_req_t out_data
);
	logic adv, head_v, issue_int, phase_q;
	logic v_s1, int_s1, last_s1;
	logic [10:0] col_s1;
	logic [11:0] row_s1;
	smd_pkg::pix_t px_s1;
	smd_pkg::pix_t [7:0] nb_s1;
	logic v_s2, int_s2, last_s2;
	logic [10:0] col_s2;
	logic [11:0] row_s2;
	smd_pkg::pix_t px_s2, med_s2, med_c;
	logic out_valid_q;
	smd_pkg::out_req_t out_q;
	logic [7:0] v [8];
	logic [2:0] rank;
	logic signed [10:0] ps, ms, ts;
	logic rep;

	assign adv       = !out_valid_q || !out_stall;
	assign head_v    = !q_stat.empty;
	assign issue_int = head.is_int && !phase_q;
	assign pop       = adv && head_v && (!issue_int || !head.is_brd);

	always_comb begin
		med_c = '0;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 8; i++) begin
				v[i] = nb_s1[i][ch*8 +: 8];
			end
			for (int i = 0; i < 8; i++) begin
				rank = 3'd0;
				for (int j = 0; j < 8; j++) begin
					if (v[j] < v[i] || (j < i && v[j] == v[i])) begin
						rank = rank + 3'd1;
					end
				end
				if (rank == 3'd4) begin
					med_c[ch*8 +: 8] = v[i];
				end
			end
		end
	end

	always_comb begin
		rep = 1'b0;
		ts  = {{2{tolerance[8]}}, tolerance};
		ps  = '0;
		ms  = '0;
		for (int ch = 0; ch < 3; ch++) begin
			ps = {3'b000, px_s2[ch*8 +: 8]};
			ms = {3'b000, med_s2[ch*8 +: 8]};
			if ((ps + ts < ms) || (ps > ms + ts)) begin
				rep = 1'b1;
			end
		end
		rep = rep && int_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (issue_int) begin
				col_s1  <= head.int_col;
				row_s1  <= head.int_row;
				px_s1   <= head.win[4];
				last_s1 <= !head.is_brd;
			end else begin
				col_s1  <= head.brd_col;
				row_s1  <= head.brd_row;
				px_s1   <= head.px;
				last_s1 <= 1'b1;
			end
			int_s1 <= issue_int;
			for (int i = 0; i < 8; i++) begin
				nb_s1[i] <= head.win[(i < 4) ? i : i + 1];
			end
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			px_s2   <= px_s1;
			med_s2  <= med_c;
			int_s2  <= int_s1;
			last_s2 <= last_s1;
			out_q.pix_col      <= col_s2;
			out_q.pix_row      <= row_s2;
			out_q.red_out      <= rep ? med_s2[23:16] : px_s2[23:16];
			out_q.green_out    <= rep ? med_s2[15:8] : px_s2[15:8];
			out_q.blue_out     <= rep ? med_s2[7:0] : px_s2[7:0];
			out_q.replaced     <= rep;
			out_q.last_of_step <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_v;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (head_v) begin
				phase_q <= issue_int && head.is_brd;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
